>>> rtl/psr_pkg.sv
// Shared types, codes and constants of the parameter slide ramp.
`default_nettype none

package psr_pkg;

    // Field and level widths.
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int EXT_BITS    = 16;
    localparam int GOAL_W      = VALUE_WIDTH + EXT_BITS;
    localparam int LEVEL_W     = 64;
    localparam int HALF_W      = LEVEL_W / 2;
    localparam int PROD_W      = 2 * LEVEL_W;

    // Fixed-point logarithm layout.
    localparam int LOG_FRAC  = 24;
    localparam int POS_W     = 6;
    localparam int LOG_W     = POS_W + LOG_FRAC;
    localparam int LF_CNT_W  = 5;
    localparam int DIV_CNT_W = 6;
    localparam logic [HALF_W-1:0] LOG_BASE = HALF_W'(128) << LOG_FRAC;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_STEP     = 2'd0;
    localparam logic [1:0] OP_START    = 2'd1;
    localparam logic [1:0] OP_RETARGET = 2'd2;
    localparam logic [1:0] OP_BREAK    = 2'd3;

    // Glide direction codes.
    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    typedef struct packed {
        logic [1:0]                    op;
        logic signed [VALUE_WIDTH-1:0] start_value;
        logic signed [VALUE_WIDTH-1:0] end_value;
    } psr_in_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          in_progress;
    } psr_out_t;

    // Datapath commands issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_LATCH,
        UOP_BREAK,
        UOP_SHOW_GOAL,
        UOP_SET_GOAL,
        UOP_BEGIN,
        UOP_SNAP,
        UOP_DIV_LOAD_LIN,
        UOP_DIV_STEP,
        UOP_LIN_FIN,
        UOP_LOAD_S,
        UOP_NORM,
        UOP_LF_LOAD_X,
        UOP_SQ,
        UOP_LF_UPD,
        UOP_SAVE_LS,
        UOP_SAVE_LT,
        UOP_DIV_LOAD_LOG,
        UOP_OFF,
        UOP_MID,
        UOP_CMP,
        UOP_EXP_FIN,
        UOP_MUL_CLR,
        UOP_PP,
        UOP_ACC,
        UOP_STEP_LIN,
        UOP_STEP_EXP,
        UOP_EMIT
    } psr_uop_t;

    // Status returned by the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       idle;
        logic       amode;
        logic       snap;
        logic       norm_done;
        logic       k_last;
        logic       div_last;
        logic       srch_done;
        logic       pp_last;
    } psr_stat_t;

endpackage

`default_nettype wire

>>> rtl/parameter_slide_ramp.sv
// Parameter slide ramp
//
// Glides a signed Q16.16 value towards a target, linearly or exponentially.
// Commands arrive as beats on the cmd channel (valid/ready); each command gives
// exactly one result beat on the res channel with the value after it and a flag
// that is high while a glide is still moving.
// Mode and slide length sit in two registers on the APB-style port; they are to
// be written while the block is idle, which the block itself does not enforce,
// and are latched by a start command or by a retarget during a glide. One
// command is worked on at a time. An exponential step runs four partial
// products through the single 32 by 32 multiplier. A linear start runs the
// 64-step divider; an exponential start runs the two logarithms, the divider
// and the 31-round exp2 search, each round 24 squarings on the shared
// multiplier.
// A new command is taken as soon as the previous result sits in the output
// register; if the receiver stalls, the next result waits until that beat is
// taken. Reset clears the levels, the glide and both registers.
`default_nettype none

module parameter_slide_ramp
    import psr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire psr_in_t            cmd,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output psr_out_t                res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic                   mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0] frames_reg, frames_next;
    logic                   cfg_wr;
    psr_uop_t               uop;
    psr_stat_t              stat;

    // Register writes complete in the access phase.
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        mode_next   = mode_reg;
        frames_next = frames_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_MODE:   mode_next   = pwdata[0];
                REG_FRAMES: frames_next = pwdata[COUNT_WIDTH-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            frames_reg <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            frames_reg <= frames_next;
        end
    end

    // Register read-back.
    assign prdata = (paddr[2] == REG_FRAMES) ? PDATA_W'(frames_reg) : PDATA_W'(mode_reg);
    assign pready = 1'b1;

    psr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .stat      (stat),
        .uop       (uop)
    );

    psr_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .uop        (uop),
        .cmd        (cmd),
        .cfg_mode   (mode_reg),
        .cfg_frames (frames_reg),
        .stat       (stat),
        .res        (res)
    );

endmodule

`default_nettype wire

>>> rtl/psr_ctrl.sv
// Sequencing state machine of the parameter slide ramp.
`default_nettype none

module psr_ctrl
    import psr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    output logic           res_valid,
    input  wire logic      res_ready,
    input  wire psr_stat_t stat,
    output psr_uop_t       uop
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_NORM,
        S_SQ,
        S_UPD,
        S_LF_END,
        S_LDIV,
        S_DIV,
        S_DIV_END,
        S_SRCH,
        S_PP,
        S_ACC,
        S_STEP_EXP,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_LOG_S,
        PH_LOG_T,
        PH_SRCH
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   res_valid_reg, res_valid_next;

    // Next state and the command for this cycle.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        uop        = UOP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    uop        = UOP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_BREAK:
                    begin
                        uop        = UOP_BREAK;
                        state_next = S_EMIT;
                    end
                    OP_STEP:
                    begin
                        if (stat.idle)
                        begin
                            uop        = UOP_SHOW_GOAL;
                            state_next = S_EMIT;
                        end
                        else if (stat.amode)
                        begin
                            uop        = UOP_MUL_CLR;
                            state_next = S_PP;
                        end
                        else
                        begin
                            uop        = UOP_STEP_LIN;
                            state_next = S_EMIT;
                        end
                    end
                    OP_RETARGET:
                    begin
                        if (stat.idle)
                        begin
                            uop        = UOP_SET_GOAL;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            uop        = UOP_BEGIN;
                            state_next = S_CHECK;
                        end
                    end
                    default:
                    begin
                        uop        = UOP_BEGIN;
                        state_next = S_CHECK;
                    end
                endcase
            end
            S_CHECK:
            begin
                if (stat.snap)
                begin
                    uop        = UOP_SNAP;
                    state_next = S_EMIT;
                end
                else if (stat.amode)
                begin
                    uop        = UOP_LOAD_S;
                    phase_next = PH_LOG_S;
                    state_next = S_NORM;
                end
                else
                begin
                    uop        = UOP_DIV_LOAD_LIN;
                    state_next = S_DIV;
                end
            end
            S_NORM:
            begin
                if (stat.norm_done)
                begin
                    uop        = UOP_LF_LOAD_X;
                    state_next = S_SQ;
                end
                else
                begin
                    uop = UOP_NORM;
                end
            end
            S_SQ:
            begin
                uop        = UOP_SQ;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                uop        = UOP_LF_UPD;
                state_next = stat.k_last ? S_LF_END : S_SQ;
            end
            S_LF_END:
            begin
                unique case (phase_reg)
                    PH_LOG_S:
                    begin
                        uop        = UOP_SAVE_LS;
                        phase_next = PH_LOG_T;
                        state_next = S_NORM;
                    end
                    PH_LOG_T:
                    begin
                        uop        = UOP_SAVE_LT;
                        state_next = S_LDIV;
                    end
                    default:
                    begin
                        uop        = UOP_CMP;
                        state_next = S_SRCH;
                    end
                endcase
            end
            S_LDIV:
            begin
                uop        = UOP_DIV_LOAD_LOG;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                uop = UOP_DIV_STEP;
                if (stat.div_last)
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                if (stat.amode)
                begin
                    uop        = UOP_OFF;
                    phase_next = PH_SRCH;
                    state_next = S_SRCH;
                end
                else
                begin
                    uop        = UOP_LIN_FIN;
                    state_next = S_EMIT;
                end
            end
            S_SRCH:
            begin
                if (stat.srch_done)
                begin
                    uop        = UOP_EXP_FIN;
                    state_next = S_EMIT;
                end
                else
                begin
                    uop        = UOP_MID;
                    state_next = S_SQ;
                end
            end
            S_PP:
            begin
                uop        = UOP_PP;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                uop        = UOP_ACC;
                state_next = stat.pp_last ? S_STEP_EXP : S_PP;
            end
            S_STEP_EXP:
            begin
                uop        = UOP_STEP_EXP;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    uop        = UOP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The result beat stays valid until the receiver takes it.
    always_comb
    begin
        res_valid_next = (uop == UOP_EMIT) || (res_valid_reg && !res_ready);
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_LOG_S;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

>>> rtl/psr_dpath.sv
// Datapath of the parameter slide ramp: levels, divider, log and exp units, multiplier.
`default_nettype none

module psr_dpath
    import psr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire psr_uop_t               uop,
    input  wire psr_in_t                cmd,
    input  wire logic                   cfg_mode,
    input  wire logic [COUNT_WIDTH-1:0] cfg_frames,
    output psr_stat_t                   stat,
    output psr_out_t                    res
);

    // Ramp state.
    logic [LEVEL_W-1:0]     cur_reg, cur_next;
    logic [GOAL_W-1:0]      goal_reg, goal_next;
    logic [LEVEL_W-1:0]     pfc_reg, pfc_next;
    logic [COUNT_WIDTH-1:0] frames_reg, frames_next;
    logic [1:0]             dir_reg, dir_next;
    logic                   amode_reg, amode_next;
    logic                   show_goal_reg, show_goal_next;

    // Working registers.
    psr_in_t                in_reg, in_next;
    logic [LEVEL_W-1:0]     x_reg, x_next;
    logic [POS_W-1:0]       p_reg, p_next;
    logic [HALF_W-1:0]      m_reg, m_next;
    logic [LOG_FRAC-1:0]    r_reg, r_next;
    logic [LF_CNT_W-1:0]    k_reg, k_next;
    logic [LOG_W-1:0]       ls_reg, ls_next;
    logic [LOG_W-1:0]       lt_reg, lt_next;
    logic [LEVEL_W-1:0]     dvd_reg, dvd_next;
    logic [COUNT_WIDTH-1:0] drem_reg, drem_next;
    logic [DIV_CNT_W-1:0]   dcnt_reg, dcnt_next;
    logic [HALF_W-1:0]      off_reg, off_next;
    logic [HALF_W-1:0]      lo_reg, lo_next;
    logic [HALF_W-1:0]      hi_reg, hi_next;
    logic [HALF_W-1:0]      mid_reg, mid_next;
    logic [PROD_W-1:0]      acc_reg, acc_next;
    logic [1:0]             idx_reg, idx_next;
    logic [LEVEL_W-1:0]     prod_reg, prod_next;
    psr_out_t               res_reg, res_next;

    // Derived values.
    logic [LEVEL_W-1:0]     goal64, s_lvl;
    logic [GOAL_W-1:0]      t_lvl;
    logic                   up_now, up_dir;
    logic [LEVEL_W-1:0]     rem_lin, next_lin, next_exp, step_next;
    logic                   over_lin, over_exp, step_over, ovf;
    logic [COUNT_WIDTH-1:0] frames_dec;
    logic [HALF_W:0]        sq;
    logic [COUNT_WIDTH:0]   dr;
    logic                   dge;
    logic                   lt_ge;
    logic [LOG_W-1:0]       ldiff;
    logic [HALF_W-1:0]      off_calc;
    logic signed [9:0]      sh;
    logic [9:0]             sh_neg;
    logic [LEVEL_W-1:0]     ratio;
    logic [HALF_W:0]        span, mid_sum;
    logic [HALF_W-1:0]      mul_a, mul_b;
    logic [1:0]             idx_sum;
    logic                   cur_pos, goal_pos;

    assign goal64 = {{(LEVEL_W-GOAL_W){goal_reg[GOAL_W-1]}}, goal_reg};
    assign s_lvl  = {{(LEVEL_W-GOAL_W){in_reg.start_value[VALUE_WIDTH-1]}},
                     in_reg.start_value, {EXT_BITS{1'b0}}};
    assign t_lvl  = {in_reg.end_value, {EXT_BITS{1'b0}}};

    assign up_now   = $signed(cur_reg) < $signed(goal64);
    assign up_dir   = (dir_reg == DIR_UP);
    assign cur_pos  = (cur_reg != '0) && !cur_reg[LEVEL_W-1];
    assign goal_pos = (goal64 != '0) && !goal64[LEVEL_W-1];

    // Linear step: compare the increment with the distance left.
    assign rem_lin  = up_dir ? (goal64 - cur_reg) : (cur_reg - goal64);
    assign over_lin = pfc_reg > rem_lin;
    assign next_lin = up_dir ? (cur_reg + pfc_reg) : (cur_reg - pfc_reg);

    // Exponential step: Q32.32 product taken from the accumulator.
    assign next_exp = acc_reg[HALF_W +: LEVEL_W];
    assign ovf      = |acc_reg[PROD_W-1:HALF_W+LEVEL_W];
    assign over_exp = up_dir ? (ovf || (next_exp > goal64)) : (next_exp < goal64);

    assign step_next  = (uop == UOP_STEP_EXP) ? next_exp : next_lin;
    assign step_over  = (uop == UOP_STEP_EXP) ? over_exp : over_lin;
    assign frames_dec = (frames_reg == '0) ? '0 : frames_reg - COUNT_WIDTH'(1);

    // One squaring of the log mantissa.
    assign sq = prod_reg[LEVEL_W-1:HALF_W-1];

    // One restoring division step.
    assign dr  = {drem_reg, dvd_reg[LEVEL_W-1]};
    assign dge = dr >= {1'b0, frames_reg};

    // Per-frame log step and the offset log.
    assign lt_ge    = lt_reg >= ls_reg;
    assign ldiff    = lt_ge ? (lt_reg - ls_reg) : (ls_reg - lt_reg);
    assign off_calc = lt_ge ? (LOG_BASE + dvd_reg[HALF_W-1:0])
                            : (LOG_BASE - dvd_reg[HALF_W-1:0]);

    // Binary search midpoint.
    assign span    = {1'b0, hi_reg} - {1'b0, lo_reg} + (HALF_W+1)'(1);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, span[HALF_W:1]};

    // Scale the exp2 mantissa by the integer part of the offset log.
    assign sh     = $signed({2'b00, off_reg[HALF_W-1:LOG_FRAC]}) - 10'sd127;
    assign sh_neg = 10'(-sh);
    always_comb
    begin
        if (!sh[9])
        begin
            if (sh > 10'sd32)
            begin
                ratio = '1;
            end
            else
            begin
                ratio = {{HALF_W{1'b0}}, lo_reg} << sh[5:0];
            end
        end
        else if (sh_neg >= 10'd64)
        begin
            ratio = '0;
        end
        else
        begin
            ratio = {{HALF_W{1'b0}}, lo_reg} >> sh_neg[5:0];
        end
    end

    // Shared 32 by 32 multiplier operands.
    always_comb
    begin
        if (uop == UOP_PP)
        begin
            mul_a = idx_reg[0] ? cur_reg[LEVEL_W-1:HALF_W] : cur_reg[HALF_W-1:0];
            mul_b = idx_reg[1] ? pfc_reg[LEVEL_W-1:HALF_W] : pfc_reg[HALF_W-1:0];
        end
        else
        begin
            mul_a = m_reg;
            mul_b = m_reg;
        end
    end
    assign prod_next = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
    assign idx_sum   = {1'b0, idx_reg[0]} + {1'b0, idx_reg[1]};

    // Command decode.
    always_comb
    begin
        cur_next       = cur_reg;
        goal_next      = goal_reg;
        pfc_next       = pfc_reg;
        frames_next    = frames_reg;
        dir_next       = dir_reg;
        amode_next     = amode_reg;
        show_goal_next = show_goal_reg;
        in_next        = in_reg;
        x_next         = x_reg;
        p_next         = p_reg;
        m_next         = m_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        ls_next        = ls_reg;
        lt_next        = lt_reg;
        dvd_next       = dvd_reg;
        drem_next      = drem_reg;
        dcnt_next      = dcnt_reg;
        off_next       = off_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        unique case (uop)
            UOP_NONE:
            begin
            end
            UOP_LATCH:
            begin
                in_next        = cmd;
                show_goal_next = 1'b0;
            end
            UOP_BREAK:
            begin
                dir_next    = DIR_IDLE;
                frames_next = '0;
                pfc_next    = '0;
            end
            UOP_SHOW_GOAL:
            begin
                show_goal_next = 1'b1;
            end
            UOP_SET_GOAL:
            begin
                goal_next = t_lvl;
            end
            UOP_BEGIN:
            begin
                if (in_reg.op == OP_START)
                begin
                    cur_next = s_lvl;
                end
                goal_next   = t_lvl;
                frames_next = cfg_frames;
                amode_next  = cfg_mode;
                pfc_next    = '0;
            end
            UOP_SNAP:
            begin
                dir_next    = DIR_IDLE;
                cur_next    = goal64;
                frames_next = '0;
            end
            UOP_DIV_LOAD_LIN:
            begin
                dvd_next  = up_now ? (goal64 - cur_reg) : (cur_reg - goal64);
                drem_next = '0;
                dcnt_next = '0;
            end
            UOP_DIV_STEP:
            begin
                drem_next = dge ? COUNT_WIDTH'(dr - {1'b0, frames_reg}) : dr[COUNT_WIDTH-1:0];
                dvd_next  = {dvd_reg[LEVEL_W-2:0], dge};
                dcnt_next = dcnt_reg + DIV_CNT_W'(1);
            end
            UOP_LIN_FIN:
            begin
                pfc_next = dvd_reg;
                dir_next = up_now ? DIR_UP : DIR_DOWN;
            end
            UOP_LOAD_S:
            begin
                x_next = cur_reg;
                p_next = '1;
            end
            UOP_NORM:
            begin
                x_next = {x_reg[LEVEL_W-2:0], 1'b0};
                p_next = p_reg - POS_W'(1);
            end
            UOP_LF_LOAD_X:
            begin
                m_next = x_reg[LEVEL_W-1:HALF_W];
                r_next = '0;
                k_next = '0;
            end
            UOP_SQ:
            begin
            end
            UOP_LF_UPD:
            begin
                r_next = {r_reg[LOG_FRAC-2:0], sq[HALF_W]};
                m_next = sq[HALF_W] ? sq[HALF_W:1] : sq[HALF_W-1:0];
                k_next = k_reg + LF_CNT_W'(1);
            end
            UOP_SAVE_LS:
            begin
                ls_next = {p_reg, r_reg};
                x_next  = goal64;
                p_next  = '1;
            end
            UOP_SAVE_LT:
            begin
                lt_next = {p_reg, r_reg};
            end
            UOP_DIV_LOAD_LOG:
            begin
                dvd_next  = {{(LEVEL_W-LOG_W){1'b0}}, ldiff};
                drem_next = '0;
                dcnt_next = '0;
            end
            UOP_OFF:
            begin
                off_next = off_calc;
                lo_next  = HALF_W'(1) << (HALF_W - 1);
                hi_next  = '1;
            end
            UOP_MID:
            begin
                mid_next = mid_sum[HALF_W-1:0];
                m_next   = mid_sum[HALF_W-1:0];
                r_next   = '0;
                k_next   = '0;
            end
            UOP_CMP:
            begin
                if (r_reg <= off_reg[LOG_FRAC-1:0])
                begin
                    lo_next = mid_reg;
                end
                else
                begin
                    hi_next = mid_reg - HALF_W'(1);
                end
            end
            UOP_EXP_FIN:
            begin
                pfc_next = ratio;
                dir_next = up_now ? DIR_UP : DIR_DOWN;
            end
            UOP_MUL_CLR:
            begin
                acc_next = '0;
                idx_next = '0;
            end
            UOP_PP:
            begin
            end
            UOP_ACC:
            begin
                acc_next = acc_reg + ({{LEVEL_W{1'b0}}, prod_reg} << {idx_sum, 5'b00000});
                idx_next = idx_reg + 2'd1;
            end
            UOP_STEP_LIN, UOP_STEP_EXP:
            begin
                if (frames_dec == '0 || step_over)
                begin
                    dir_next    = DIR_IDLE;
                    cur_next    = goal64;
                    frames_next = '0;
                end
                else
                begin
                    cur_next    = step_next;
                    frames_next = frames_dec;
                end
            end
            UOP_EMIT:
            begin
                res_next.value       = show_goal_reg ? goal_reg[GOAL_W-1:EXT_BITS]
                                                     : cur_reg[GOAL_W-1:EXT_BITS];
                res_next.in_progress = (dir_reg != DIR_IDLE);
            end
            default:
            begin
            end
        endcase
    end

    // Ramp state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            goal_reg      <= '0;
            pfc_reg       <= '0;
            frames_reg    <= '0;
            dir_reg       <= DIR_IDLE;
            amode_reg     <= 1'b0;
            show_goal_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            goal_reg      <= goal_next;
            pfc_reg       <= pfc_next;
            frames_reg    <= frames_next;
            dir_reg       <= dir_next;
            amode_reg     <= amode_next;
            show_goal_reg <= show_goal_next;
        end
    end

    // Working registers, no reset needed.
    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        x_reg    <= x_next;
        p_reg    <= p_next;
        m_reg    <= m_next;
        r_reg    <= r_next;
        k_reg    <= k_next;
        ls_reg   <= ls_next;
        lt_reg   <= lt_next;
        dvd_reg  <= dvd_next;
        drem_reg <= drem_next;
        dcnt_reg <= dcnt_next;
        off_reg  <= off_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        acc_reg  <= acc_next;
        idx_reg  <= idx_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    // Status towards the controller.
    always_comb
    begin
        stat.op        = in_reg.op;
        stat.idle      = (dir_reg == DIR_IDLE);
        stat.amode     = amode_reg;
        stat.snap      = (frames_reg == '0) || (cur_reg == goal64)
                         || (amode_reg && (!cur_pos || !goal_pos));
        stat.norm_done = x_reg[LEVEL_W-1];
        stat.k_last    = (k_reg == LF_CNT_W'(LOG_FRAC - 1));
        stat.div_last  = (dcnt_reg == '1);
        stat.srch_done = !(lo_reg < hi_reg);
        stat.pp_last   = (idx_reg == 2'd3);
    end

    assign res = res_reg;

endmodule

`default_nettype wire

>>> rtl/psr_checker.sv
// Port-level checks of the parameter slide ramp and their binding.
`default_nettype none

module psr_port_checks
    import psr_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     cmd_valid,
    input wire logic     cmd_ready,
    input wire logic     res_valid,
    input wire logic     res_ready,
    input wire psr_out_t res
);

    // A stalled result beat stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res))
        else $error("result payload changed while stalled");

    // Once a command is taken the block is busy with it.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while another is in work");

    // A new result only appears at the end of a command.
    a_res_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!cmd_ready))
        else $error("result raised without a command in work");

endmodule

bind parameter_slide_ramp psr_port_checks u_psr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

`default_nettype wire

>>> verif/psr_checker.sv
// Checker for the parameter slide ramp: watches both channels and the register port, predicts and compares.
`default_nettype none

module psr_checker
    import psr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire logic               cmd_ready,
    input  wire psr_in_t            cmd,
    input  wire logic               res_valid,
    input  wire logic               res_ready,
    input  wire psr_out_t           res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    input  wire logic               pready,
    output int                      fail_count,
    output int                      pending
);

    // Register copies and glide state of the predictor.
    bit         mode_reg;
    bit [15:0]  frames_reg;
    bit [63:0]  level;
    bit [63:0]  goal;
    bit [63:0]  frame_delta;
    bit [63:0]  frames_left;
    bit [1:0]   glide_dir;
    bit         glide_mode;
    psr_out_t   expected_results[$];

    // Sign-extends a Q16.16 value and adds the extra fraction bits.
    function automatic bit [63:0] widen(logic signed [VALUE_WIDTH-1:0] v);
        bit [63:0] x;
        x = {{(64-VALUE_WIDTH){v[VALUE_WIDTH-1]}}, v};
        return x << EXT_BITS;
    endfunction

    function automatic bit positive(bit [63:0] x);
        return x != 0 && !x[63];
    endfunction

    // Fraction bits of log2 by repeated squaring of a Q1.31 mantissa.
    function automatic bit [63:0] log_fraction(bit [63:0] m);
        bit [63:0] r;
        bit [63:0] sq;
        r = 0;
        for (int k = 0; k < LOG_FRAC; k++)
        begin
            sq = (m * m) >> 31;
            r = r << 1;
            if (sq >= 64'h1_0000_0000)
            begin
                r = r | 64'd1;
                m = sq >> 1;
            end
            else
                m = sq;
        end
        return r;
    endfunction

    function automatic bit [63:0] log2_level(bit [63:0] x);
        int        p;
        bit [63:0] m;
        p = 0;
        for (int i = 0; i < 64; i++)
            if (x[i])
                p = i;
        m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
        return (64'(p) << LOG_FRAC) | log_fraction(m);
    endfunction

    // Ratio as Q32.32 from an offset log: mantissa found by binary search.
    function automatic bit [63:0] ratio_of(bit [63:0] off_log);
        bit [63:0] f;
        bit [63:0] lo;
        bit [63:0] hi;
        bit [63:0] mid;
        int        ip;
        int        sh;
        f  = off_log & 64'hFF_FFFF;
        ip = int'(off_log >> LOG_FRAC) - 128;
        lo = 64'h8000_0000;
        hi = 64'hFFFF_FFFF;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            if (log_fraction(mid) <= f)
                lo = mid;
            else
                hi = mid - 1;
        end
        sh = ip + 1;
        if (sh >= 0)
            return (sh > 32) ? ~64'd0 : (lo << sh);
        if (-sh >= 64)
            return 64'd0;
        return lo >> (-sh);
    endfunction

    function automatic void snap();
        glide_dir   = DIR_IDLE;
        level       = goal;
        frames_left = 0;
    endfunction

    function automatic void begin_glide(bit [63:0] s, bit [63:0] t);
        bit [63:0] n;
        bit [63:0] ls;
        bit [63:0] lt;
        bit [63:0] base;
        bit [63:0] mag;
        bit        up;
        n           = 64'(frames_reg);
        level       = s;
        goal        = t;
        frames_left = n;
        glide_mode  = mode_reg;
        frame_delta = 0;
        if (n == 0 || s == t || (glide_mode && (!positive(s) || !positive(t))))
        begin
            snap();
            return;
        end
        up = $signed(s) < $signed(t);
        if (glide_mode)
        begin
            ls   = log2_level(s);
            lt   = log2_level(t);
            base = 64'(LOG_BASE);
            frame_delta = ratio_of(lt >= ls ? base + (lt - ls) / n : base - (ls - lt) / n);
        end
        else
        begin
            mag = up ? t - s : s - t;
            frame_delta = up ? mag / n : 64'd0 - mag / n;
        end
        glide_dir = up ? DIR_UP : DIR_DOWN;
    endfunction

    // Applies one command beat and returns the result it should give.
    function automatic psr_out_t apply_command(psr_in_t c);
        bit [63:0]  shown;
        bit [63:0]  nxt;
        bit [63:0]  rem;
        bit [63:0]  mag;
        bit [127:0] prod;
        bit         up;
        bit         over;
        psr_out_t   r;
        shown = level;
        case (c.op)
            OP_START:
            begin
                begin_glide(widen(c.start_value), widen(c.end_value));
                shown = level;
            end
            OP_RETARGET:
            begin
                goal = widen(c.end_value);
                if (glide_dir != DIR_IDLE)
                    begin_glide(level, goal);
                shown = level;
            end
            OP_BREAK:
            begin
                glide_dir   = DIR_IDLE;
                frames_left = 0;
                frame_delta = 0;
            end
            default:
            begin
                if (glide_dir == DIR_IDLE)
                    shown = goal;
                else
                begin
                    up = glide_dir == DIR_UP;
                    if (glide_mode)
                    begin
                        prod = 128'(level) * 128'(frame_delta);
                        nxt  = prod[95:32];
                        over = up ? (prod[127:96] != 0 || nxt > goal) : (nxt < goal);
                    end
                    else
                    begin
                        rem  = up ? goal - level : level - goal;
                        mag  = up ? frame_delta : 64'd0 - frame_delta;
                        over = mag > rem;
                        nxt  = up ? level + mag : level - mag;
                    end
                    if (frames_left > 0)
                        frames_left = frames_left - 1;
                    if (frames_left == 0 || over)
                        snap();
                    else
                        level = nxt;
                    shown = level;
                end
            end
        endcase
        r.value       = shown[EXT_BITS +: VALUE_WIDTH];
        r.in_progress = glide_dir != DIR_IDLE;
        return r;
    endfunction

    // Register writes, command beats and result beats, all seen at the clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        psr_out_t exp_res;
        if (!rst_n)
        begin
            mode_reg    = 0;
            frames_reg  = 0;
            level       = 0;
            goal        = 0;
            frame_delta = 0;
            frames_left = 0;
            glide_dir   = DIR_IDLE;
            glide_mode  = 0;
            fail_count  = 0;
            expected_results.delete();
            pending     = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1:2] == 1'(REG_MODE))
                    mode_reg = pwdata[0];
                else if (paddr[PADDR_W-1:2] == 1'(REG_FRAMES))
                    frames_reg = pwdata[COUNT_WIDTH-1:0];
            end
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: value %h in_progress %b",
                                 res.value, res.in_progress);
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (res.value !== exp_res.value || res.in_progress !== exp_res.in_progress)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result differs: expected value %h in_progress %b, got %h %b",
                                     exp_res.value, exp_res.in_progress,
                                     res.value, res.in_progress);
                    end
                end
            end
            if (cmd_valid && cmd_ready)
                expected_results.push_back(apply_command(cmd));
            pending = expected_results.size();
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Top of the parameter slide ramp testbench: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top
    import psr_pkg::*;
;

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_ready;
    psr_in_t            cmd;
    logic               res_valid;
    logic               res_ready;
    psr_out_t           res;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    bit                 idling_on;
    bit                 long_hold;
    int                 quiet_cycles;

    parameter_slide_ramp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    psr_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Register write: setup cycle, then access cycle.
    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel    <= 0;
        penable <= 0;
    endtask

    task automatic set_glide(bit expo, logic [15:0] frames);
        reg_write(PADDR_W'(4 * REG_MODE), PDATA_W'(expo));
        @(posedge clk);
        reg_write(PADDR_W'(4 * REG_FRAMES), PDATA_W'(frames));
        @(posedge clk);
    endtask

    // Waits until every expected result has come back.
    task automatic drain();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Offers one command beat until it is accepted, at times followed by an idle gap.
    task automatic send(logic [1:0] op, logic [31:0] s, logic [31:0] t);
        cmd_valid <= 1;
        cmd       <= '{op: op, start_value: s, end_value: t};
        @(negedge clk);
        while (!cmd_ready)
            @(negedge clk);
        @(posedge clk);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            cmd_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_value(bit expo);
        case ($urandom_range(0, 3))
            0: return expo ? 32'($urandom_range(1, 32'h00FF_FFFF)) : $urandom;
            1: return 32'($urandom_range(1, 32'h7FFF_FFFF));
            2: return expo ? 32'($urandom_range(32'h0001_0000, 32'h0100_0000)) : $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        res_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                res_ready <= 0;
                repeat (400) @(posedge clk);
                long_hold = 0;
            end
            else if (idling_on && $urandom_range(0, 6) == 0)
            begin
                res_ready <= 0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
                res_ready <= 1;
        end
    end

    // Watchdog on cycles without any beat or register write.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 30000)
            begin
                $display("parameter_slide_ramp: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        bit          expo;
        int          count;
        int          len;
        logic [15:0] frames;
        cmd_valid = 0;
        cmd       = '0;
        psel      = 0;
        penable   = 0;
        pwrite    = 0;
        paddr     = '0;
        pwdata    = '0;
        idling_on = 0;
        long_hold = 0;
        rst_n     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Linear glides over four frames: idle step, full range, equal ends, retarget, break.
        set_glide(0, 4);
        send(OP_STEP, 32'h0, 32'h0);
        send(OP_START, 32'h8000_0000, 32'h7FFF_FFFF);
        send(OP_STEP, 32'h0, 32'h0);
        send(OP_RETARGET, 32'h0, 32'h8000_0000);
        send(OP_STEP, 32'h0, 32'h0);
        send(OP_BREAK, 32'h0, 32'h0);
        send(OP_STEP, 32'h0, 32'h0);
        send(OP_RETARGET, 32'h0, 32'h0001_0000);
        send(OP_START, 32'h1234_5678, 32'h1234_5678);
        send(OP_START, 32'h0000_0000, 32'h0000_0003);
        repeat (5) send(OP_STEP, 32'h0, 32'h0);
        cmd_valid <= 0;
        drain();

        // Exponential glides: rising, falling, a non-positive start.
        set_glide(1, 3);
        send(OP_START, 32'h0001_0000, 32'h0008_0000);
        repeat (4) send(OP_STEP, 32'h0, 32'h0);
        send(OP_START, 32'h7FFF_FFFF, 32'h0000_0001);
        send(OP_STEP, 32'h0, 32'h0);
        send(OP_START, 32'hFFFF_0000, 32'h0001_0000);
        cmd_valid <= 0;
        drain();

        // Zero length, then the longest glide with a tiny increment.
        set_glide(0, 0);
        send(OP_START, 32'h0000_0100, 32'h0100_0000);
        cmd_valid <= 0;
        drain();
        set_glide(0, 16'hFFFF);
        send(OP_START, 32'h0000_0000, 32'h0000_0001);
        repeat (3) send(OP_STEP, 32'h0, 32'h0);
        cmd_valid <= 0;
        drain();

        // Random phases: a start, then mostly steps, with some noise.
        idling_on = 1;
        count = 0;
        for (int ph = 0; count < 500; ph++)
        begin
            expo   = $urandom_range(0, 2) == 0;
            frames = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
            if (ph % 9 == 8)
                frames = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
            if (count > 430)
                idling_on = 0;
            set_glide(expo, frames);
            if (ph == 3)
                long_hold = 1;
            send(OP_START, pick_value(expo), pick_value(expo));
            count++;
            len = $urandom_range(4, 20);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(0, 19))
                    0: send(OP_RETARGET, $urandom, pick_value(expo));
                    1: send(OP_BREAK, $urandom, $urandom);
                    2: send(OP_START, pick_value(expo), pick_value(expo));
                    default: send(OP_STEP, $urandom, $urandom);
                endcase
                count++;
            end
            cmd_valid <= 0;
            drain();
        end

        cmd_valid <= 0;
        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("parameter_slide_ramp: match");
        else
            $display("parameter_slide_ramp: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
